FILE: hw/rtl/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Types, constants and character helpers shared by the JSON syntax checker.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int MAX_NESTING_DEF = 64;
  localparam int LIMIT_W         = 7;
  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RST = 7'd64;

  // container kinds as kept on the nesting stack
  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  // characters of the grammar
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_E    = 8'h45;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_B    = 8'h62;
  localparam logic [7:0] CH_LO_E    = 8'h65;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_L    = 8'h6C;
  localparam logic [7:0] CH_LO_N    = 8'h6E;
  localparam logic [7:0] CH_LO_R    = 8'h72;
  localparam logic [7:0] CH_LO_S    = 8'h73;
  localparam logic [7:0] CH_LO_T    = 8'h74;
  localparam logic [7:0] CH_LO_U    = 8'h75;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  typedef enum logic [4:0] {
    PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_OBJ_KEY, PH_COLON, PH_AFTER,
    PH_STR_V, PH_STR_K, PH_ESC_V, PH_ESC_K, PH_HEX_V, PH_HEX_K,
    PH_NUM_MINUS, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_DOT, PH_NUM_FRAC,
    PH_NUM_E, PH_NUM_ESIGN, PH_NUM_EXP,
    PH_LIT_T, PH_LIT_F, PH_LIT_N
  } phase_t;

  typedef struct packed {
    logic valid_res;
    logic depth_exceeded;
  } verdict_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  // length of the literal word of a literal phase
  function automatic logic [2:0] lit_len(input phase_t ph);
    logic [2:0] len;
    case (ph)
      PH_LIT_F: len = 3'd5;
      default:  len = 3'd4;
    endcase
    return len;
  endfunction

  // expected letter of a literal word at a position
  function automatic logic [7:0] lit_char(input phase_t ph, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_SPACE;
    case (ph)
      PH_LIT_T: begin
        case (pos)
          3'd0:    ch = CH_LO_T;
          3'd1:    ch = CH_LO_R;
          3'd2:    ch = CH_LO_U;
          3'd3:    ch = CH_LO_E;
          default: ch = CH_SPACE;
        endcase
      end
      PH_LIT_F: begin
        case (pos)
          3'd0:    ch = CH_LO_F;
          3'd1:    ch = CH_LO_A;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_S;
          3'd4:    ch = CH_LO_E;
          default: ch = CH_SPACE;
        endcase
      end
      PH_LIT_N: begin
        case (pos)
          3'd0:    ch = CH_LO_N;
          3'd1:    ch = CH_LO_U;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_L;
          default: ch = CH_SPACE;
        endcase
      end
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/jsv_stack_mem.sv
// ----------------------------------------------------------------------------
// jsv_stack_mem
// Nesting stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module jsv_stack_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/jsv_out_buf.sv
// ----------------------------------------------------------------------------
// jsv_out_buf
// Two-slot verdict buffer: output register plus a skid slot.
// ----------------------------------------------------------------------------
module jsv_out_buf
  import jsv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_push,
  input  verdict_t res_data,
  output logic     space_ok,
  output logic     out_valid,
  input  logic     out_ready,
  output verdict_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  verdict_t out_data_r, out_data_nxt;
  verdict_t skid_data_r, skid_data_nxt;
  logic     pop;

  assign pop       = out_valid_r && out_ready;
  assign space_ok  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r) begin
      if (pop) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

FILE: hw/rtl/jsv_core.sv
// ----------------------------------------------------------------------------
// jsv_core
// Grammar state machine; the nesting stack lives in a synchronous memory,
// with the top entry and the entry below it held in registers.
// ----------------------------------------------------------------------------
module jsv_core
  import jsv_pkg::*;
#(
  parameter int MAX_NESTING = MAX_NESTING_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  logic [7:0]         text_byte,
  input  logic               last_byte,
  input  logic [LIMIT_W-1:0] depth_limit,
  output logic               res_push,
  output verdict_t           res_data
);

  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam int AW    = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int CMP_W = (LVL_W > LIMIT_W) ? LVL_W : LIMIT_W;

  phase_t           phase_r, phase_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [2:0]       sub_r, sub_nxt;
  logic             failed_r, failed_nxt;
  logic             ovf_r, ovf_nxt;
  logic             top_r, top_nxt;

  logic             below;
  logic             push;
  logic             push_kind;
  logic             do_start;
  logic             do_after;
  logic             key;
  logic             ok;
  logic             exc;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       c;

  assign c = text_byte;

  always_comb begin
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    sub_nxt    = sub_r;
    failed_nxt = failed_r;
    ovf_nxt    = ovf_r;
    top_nxt    = top_r;
    push       = 1'b0;
    push_kind  = KIND_ARRAY;
    do_start   = 1'b0;
    do_after   = 1'b0;
    key        = 1'b0;
    ok         = 1'b0;
    exc        = 1'b0;
    rd_addr    = '0;

    if (byte_fire && !failed_r) begin
      case (phase_r)
        PH_VALUE: do_start = 1'b1;
        PH_ARR_FIRST: begin
          if (c == CH_RBRACK) do_after = 1'b1;
          else                do_start = 1'b1;
        end
        PH_OBJ_FIRST, PH_OBJ_KEY: begin
          if (!is_ws(c)) begin
            if (c == CH_QUOTE) phase_nxt = PH_STR_K;
            else if (c == CH_RBRACE && phase_r == PH_OBJ_FIRST) do_after = 1'b1;
            else failed_nxt = 1'b1;
          end
        end
        PH_COLON: begin
          if (!is_ws(c)) begin
            if (c == CH_COLON) phase_nxt = PH_VALUE;
            else               failed_nxt = 1'b1;
          end
        end
        PH_AFTER: do_after = 1'b1;
        PH_STR_V, PH_STR_K: begin
          key = (phase_r == PH_STR_K);
          if (c == CH_QUOTE)       phase_nxt = key ? PH_COLON : PH_AFTER;
          else if (c == CH_BSLASH) phase_nxt = key ? PH_ESC_K : PH_ESC_V;
          else if (c < CH_SPACE)   failed_nxt = 1'b1;
        end
        PH_ESC_V, PH_ESC_K: begin
          key = (phase_r == PH_ESC_K);
          if (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LO_B, CH_LO_F,
                        CH_LO_N, CH_LO_R, CH_LO_T}) begin
            phase_nxt = key ? PH_STR_K : PH_STR_V;
          end else if (c == CH_LO_U) begin
            sub_nxt   = 3'd0;
            phase_nxt = key ? PH_HEX_K : PH_HEX_V;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_HEX_V, PH_HEX_K: begin
          key = (phase_r == PH_HEX_K);
          if (!is_hex(c)) begin
            failed_nxt = 1'b1;
          end else begin
            sub_nxt = sub_r + 3'd1;
            if (sub_nxt >= 3'd4) phase_nxt = key ? PH_STR_K : PH_STR_V;
          end
        end
        PH_NUM_MINUS: begin
          if (c == CH_ZERO)                         phase_nxt = PH_NUM_ZERO;
          else if (c >= CH_ONE && c <= CH_NINE)     phase_nxt = PH_NUM_INT;
          else                                      failed_nxt = 1'b1;
        end
        PH_NUM_ZERO, PH_NUM_INT: begin
          if (!(is_digit(c) && phase_r == PH_NUM_INT)) begin
            if (c == CH_DOT)                            phase_nxt = PH_NUM_DOT;
            else if (c == CH_LO_E || c == CH_UP_E)      phase_nxt = PH_NUM_E;
            else                                        do_after  = 1'b1;
          end
        end
        PH_NUM_DOT: begin
          if (is_digit(c)) phase_nxt = PH_NUM_FRAC;
          else             failed_nxt = 1'b1;
        end
        PH_NUM_FRAC: begin
          if (!is_digit(c)) begin
            if (c == CH_LO_E || c == CH_UP_E) phase_nxt = PH_NUM_E;
            else                              do_after  = 1'b1;
          end
        end
        PH_NUM_E: begin
          if (c == CH_PLUS || c == CH_MINUS) phase_nxt = PH_NUM_ESIGN;
          else if (is_digit(c))              phase_nxt = PH_NUM_EXP;
          else                               failed_nxt = 1'b1;
        end
        PH_NUM_ESIGN: begin
          if (is_digit(c)) phase_nxt = PH_NUM_EXP;
          else             failed_nxt = 1'b1;
        end
        PH_NUM_EXP: begin
          if (!is_digit(c)) do_after = 1'b1;
        end
        PH_LIT_T, PH_LIT_F, PH_LIT_N: begin
          if (sub_r >= lit_len(phase_r) || lit_char(phase_r, sub_r) != c) begin
            failed_nxt = 1'b1;
          end else begin
            sub_nxt = sub_r + 3'd1;
            if (sub_nxt == lit_len(phase_r)) phase_nxt = PH_AFTER;
          end
        end
        default: failed_nxt = 1'b1;
      endcase

      // start of a value
      if (do_start && !is_ws(c)) begin
        sub_nxt = 3'd1;
        if (c == CH_LBRACE || c == CH_LBRACK) begin
          if ((CMP_W'(level_r) >= CMP_W'(depth_limit)) ||
              (level_r >= LVL_W'(MAX_NESTING))) begin
            ovf_nxt    = 1'b1;
            failed_nxt = 1'b1;
          end else begin
            push      = 1'b1;
            push_kind = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
            level_nxt = level_r + LVL_W'(1);
            top_nxt   = push_kind;
            phase_nxt = (c == CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
          end
        end
        else if (c == CH_QUOTE)                  phase_nxt = PH_STR_V;
        else if (c == CH_MINUS)                  phase_nxt = PH_NUM_MINUS;
        else if (c == CH_ZERO)                   phase_nxt = PH_NUM_ZERO;
        else if (c >= CH_ONE && c <= CH_NINE)    phase_nxt = PH_NUM_INT;
        else if (c == CH_LO_T)                   phase_nxt = PH_LIT_T;
        else if (c == CH_LO_F)                   phase_nxt = PH_LIT_F;
        else if (c == CH_LO_N)                   phase_nxt = PH_LIT_N;
        else                                     failed_nxt = 1'b1;
      end

      // end of a value: separator, closer or whitespace
      if (do_after) begin
        phase_nxt = PH_AFTER;
        if (!is_ws(c)) begin
          if (level_r == '0) begin
            failed_nxt = 1'b1;
          end else if (c == CH_COMMA) begin
            phase_nxt = (top_r == KIND_OBJECT) ? PH_OBJ_KEY : PH_VALUE;
          end else if ((c == CH_RBRACK && top_r == KIND_ARRAY) ||
                       (c == CH_RBRACE && top_r == KIND_OBJECT)) begin
            level_nxt = level_r - LVL_W'(1);
            top_nxt   = below;
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
    end

    ok = !failed_nxt && (level_nxt == '0) &&
         (phase_nxt inside {PH_AFTER, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP});
    exc = ovf_nxt;

    if (byte_fire && last_byte) begin
      phase_nxt  = PH_VALUE;
      level_nxt  = '0;
      sub_nxt    = 3'd0;
      failed_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end

    // read ahead the entry below the new top so a pop finds it registered
    if (level_nxt > LVL_W'(1)) begin
      rd_addr = AW'(level_nxt - LVL_W'(2));
    end
  end

  assign res_push                = byte_fire && last_byte;
  assign res_data.valid_res      = ok;
  assign res_data.depth_exceeded = exc;

  jsv_stack_mem #(
    .DEPTH (MAX_NESTING),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (AW'(level_r)),
    .wr_data (push_kind),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VALUE;
      level_r  <= '0;
      sub_r    <= 3'd0;
      failed_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      sub_r    <= sub_nxt;
      failed_r <= failed_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

endmodule

FILE: hw/rtl/json_syntax_validator_top.sv
// ----------------------------------------------------------------------------
// json_syntax_validator_top
// Streaming JSON syntax checker, one text byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready channel, one text byte per item; in_last_byte marks
//            the final byte of a text.
//   out_*  : valid/ready channel, one verdict item per text (valid flag and
//            nesting overflow flag), given for the byte marked last.
//   cfg_*  : cfg_we writes cfg_wdata into the depth limit at once; write only
//            while no text is in flight. Limit in force is the smaller of the
//            register and MAX_NESTING.
// Throughput: one byte per cycle while in_ready is high. The grammar state
//   and the two top stack entries are registers; the stack memory is read one
//   level ahead so a closing bracket does not hold up the input.
// Output: the verdict for the last byte is registered in the output buffer.
// Stall: a two-slot output buffer keeps input flowing while one verdict waits;
//   in_ready drops only when two verdicts are held.
// Reset: synchronous rst_n clears the parser to the start of a text and sets
//   the depth limit to 64; stack memory contents need no clearing.
// ----------------------------------------------------------------------------
module json_syntax_validator_top
  import jsv_pkg::*;
#(
  parameter int MAX_NESTING = MAX_NESTING_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic               out_depth_exceeded,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] depth_limit_r;
  logic               byte_fire;
  logic               res_push;
  logic               space_ok;
  verdict_t           res_data;
  verdict_t           out_data;

  assign in_ready  = space_ok;
  assign byte_fire = in_valid && space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_limit_r <= DEPTH_LIMIT_RST;
    end else if (cfg_we) begin
      depth_limit_r <= cfg_wdata;
    end
  end

  jsv_core #(
    .MAX_NESTING (MAX_NESTING)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (byte_fire),
    .text_byte   (in_text_byte),
    .last_byte   (in_last_byte),
    .depth_limit (depth_limit_r),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  jsv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_valid_res      = out_data.valid_res;
  assign out_depth_exceeded = out_data.depth_exceeded;

endmodule
